// File: hdl/kvs_pkg.sv
package kvs_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int WORD_W      = 1 + KEY_W + VAL_W;

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        KVS_CLEAR,
        KVS_IDLE,
        KVS_SCAN,
        KVS_DONE
    } kvs_state_t;

endpackage

// File: hdl/kvs_ram.sv
module kvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/key_value_store_unit.sv
// Each accepted request scans every entry of the single-port table memory,
//   then writes back at most once; a new request is taken only after the
//   previous result has been loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset: asynchronous, active low; then a clearing pass marks every entry
//   free, with in_ready low during it.
module key_value_store_unit #(
    parameter int ENTRIES = kvs_pkg::ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [kvs_pkg::OP_W-1:0]            opcode,
    input  logic signed [kvs_pkg::KEY_W-1:0]    lookup_key,
    input  logic signed [kvs_pkg::VAL_W-1:0]    put_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kvs_pkg::ST_W-1:0]            status,
    output logic signed [kvs_pkg::VAL_W-1:0]    read_value
);

    import kvs_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    kvs_state_t state_reg, state_next;

    logic [CW-1:0]     cnt_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;

    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;

    logic              hit_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [VAL_W-1:0]  hit_val_reg;
    logic              free_reg;
    logic [AW-1:0]     free_idx_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [VAL_W-1:0]  rv_reg, rv_next;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    logic              ent_valid;
    logic [KEY_W-1:0]  ent_key;
    logic [VAL_W-1:0]  ent_val;
    logic              accept;
    logic              issue;
    logic              out_free;
    logic              load_out;

    kvs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign ent_valid = mem_rdata[WORD_W-1];
    assign ent_key   = mem_rdata[VAL_W +: KEY_W];
    assign ent_val   = mem_rdata[VAL_W-1:0];

    assign in_ready   = (state_reg == KVS_IDLE);
    assign accept     = in_valid && in_ready;
    assign issue      = (state_reg == KVS_SCAN) && (cnt_reg != CW'(ENTRIES));
    assign out_free   = !out_valid_reg || out_ready;
    assign load_out   = (state_reg == KVS_DONE) && out_free;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = rv_reg;

    always_comb
    begin
        state_next  = state_reg;
        mem_we      = 1'b0;
        mem_addr    = cnt_reg[AW-1:0];
        mem_wdata   = {1'b1, key_reg, val_reg};
        status_next = ST_DONE;
        rv_next     = '0;
        unique case (state_reg)
            KVS_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (cnt_reg == CW'(ENTRIES - 1))
                begin
                    state_next = KVS_IDLE;
                end
            end
            KVS_IDLE:
            begin
                if (accept)
                begin
                    state_next = KVS_SCAN;
                end
            end
            KVS_SCAN:
            begin
                if (cnt_reg == CW'(ENTRIES))
                begin
                    state_next = KVS_DONE;
                end
            end
            KVS_DONE:
            begin
                unique case (op_reg)
                    OP_PUT:
                    begin
                        if (hit_reg)
                        begin
                            mem_we   = load_out;
                            mem_addr = hit_idx_reg;
                        end
                        else if (free_reg)
                        begin
                            mem_we   = load_out;
                            mem_addr = free_idx_reg;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_GET:
                    begin
                        if (hit_reg)
                        begin
                            rv_next = hit_val_reg;
                        end
                        else
                        begin
                            status_next = ST_ABSENT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            mem_we    = load_out;
                            mem_addr  = hit_idx_reg;
                            mem_wdata = {1'b0, key_reg, val_reg};
                        end
                        else
                        begin
                            status_next = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
                if (out_free)
                begin
                    state_next = KVS_IDLE;
                end
            end
            default:
            begin
                state_next = KVS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= KVS_CLEAR;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            if (state_reg == KVS_CLEAR)
            begin
                cnt_reg <= (state_next == KVS_IDLE) ? '0 : cnt_reg + CW'(1);
            end
            else if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (accept)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (rd_vld_reg)
            begin
                if (!hit_reg && ent_valid && (ent_key == key_reg))
                begin
                    hit_reg <= 1'b1;
                end
                if (!free_reg && !ent_valid)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[AW-1:0];
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= lookup_key;
            val_reg <= put_value;
        end
        if (rd_vld_reg && !hit_reg && ent_valid && (ent_key == key_reg))
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_val_reg <= ent_val;
        end
        if (rd_vld_reg && !free_reg && !ent_valid)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (load_out)
        begin
            status_reg <= status_next;
            rv_reg     <= rv_next;
        end
    end

    // note: checks
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == KVS_CLEAR) |-> !in_ready)
        else $error("request taken during clearing pass");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == KVS_SCAN))
        else $error("accepted request did not start a scan");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == KVS_CLEAR || state_reg == KVS_DONE))
        else $error("table written outside clear or write-back");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_DONE) |-> (rv_reg == '0))
        else $error("nonzero value on a miss or full result");

    a_no_scan_read_late: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == KVS_DONE) |-> !rd_vld_reg)
        else $error("scan read still pending at write-back");

endmodule
